// File: rtl/kpc_pkg.sv
// Shared types, constants and helpers of the k-means point clusterer.
package kpc_pkg;

   localparam int CoordW         = 16;
   localparam int SqW            = 2 * (CoordW + 1);
   localparam int DistW          = SqW + 2;
   localparam int DefMaxPoints   = 1024;
   localparam int DefMaxClusters = 8;
   localparam int CsrW           = 32;
   localparam int IndexW         = 10;
   localparam logic [31:0] LfsrMask = 32'h8020_0003;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_QUERY    = 1'b1;
   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_LABEL  = 1'b1;

   typedef enum logic [1:0] {
      CSR_NUM_CLUSTERS,
      CSR_STOP_THRESHOLD,
      CSR_RANDOM_SEED,
      CSR_MAX_ITERATIONS
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SEED_STEP,
      ST_SEED_WR,
      ST_SEED_PUT,
      ST_ITER_START,
      ST_ASSIGN,
      ST_UPD_CHECK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DIST,
      ST_DIST_ACC,
      ST_SQRT_START,
      ST_SQRT_WAIT,
      ST_UPD_PUT,
      ST_UPD_NEXT,
      ST_ITER_END,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic                     op;
      logic signed [CoordW-1:0] coord_x;
      logic signed [CoordW-1:0] coord_y;
      logic signed [CoordW-1:0] coord_z;
      logic                     is_last;
      logic [IndexW-1:0]        point_index;
   } kpc_req_type;

   typedef struct packed {
      logic       kind;
      logic [2:0] cluster_label;
      logic       label_valid;
      logic [7:0] iterations_used;
      logic       converged;
      logic       overflowed;
   } kpc_rsp_type;

   typedef struct packed {
      logic clear;
      logic write;
      logic accum;
   } kpc_cell_ctl_type;

   function automatic logic [31:0] lfsr_step(input logic [31:0] cur);
      logic [31:0] nxt;
      nxt = cur >> 1;
      if (cur[0]) begin
         nxt = nxt ^ LfsrMask;
      end
      return nxt;
   endfunction

endpackage

// File: rtl/kmeans_point_clusterer_unit.sv
// Top level: point and label stores, cell chain, seeding and update sequencer.
// Load: accepted every cycle while not busy, no result. Query: result in the next cycle.
// Load with is_last: busy for seeding each center, then per iteration to clear,
// assign every point through the cell chain and test for the stop, plus, per non-empty
// cluster, the serial divider and square root (an empty one is skipped); the report
// follows in the next cycle.
// Reset (synchronous) restores the control registers, centers and box; stores are not cleared.
module kmeans_point_clusterer_unit import kpc_pkg::*; #(
   parameter int MAX_POINTS   = DefMaxPoints,
   parameter int MAX_CLUSTERS = DefMaxClusters
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  kpc_req_type     req_data,
   output logic            rsp_valid,
   output kpc_rsp_type     rsp_data,
   input  logic            csr_wr_en,
   input  csr_index_type   csr_index,
   input  logic [CsrW-1:0] csr_wdata
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CW    = $clog2(MAX_POINTS + 1);
   localparam int LW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int KW    = $clog2(MAX_CLUSTERS + 1);
   localparam int SUM_W = CoordW + CW;
   localparam int MW    = DistW / 2 + KW;

   state_type state_ff, state_in;

   logic [3:0]  num_clusters_ff;
   logic [15:0] stop_thr_ff;
   logic [7:0]  max_iter_ff;
   logic [31:0] lfsr_ff;
   logic [31:0] lfsr_nx;

   logic [CW-1:0]          point_count_ff;
   logic [2:0][CoordW-1:0] box_min_ff, box_max_ff;
   logic [2:0][CoordW-1:0] box_min_eff, box_max_eff;
   logic                   batch_done_ff, ovf_ff, conv_ff;
   logic [7:0]             iter_ff, iter_nx, cap_eff;
   logic [KW-1:0]          k_eff;

   logic [LW-1:0]  cell_ff;
   logic [1:0]     axis_ff;
   logic [CW-1:0]  feed_ff, tail_ff;
   logic           feed_v_ff;
   logic           q_pend_ff, q_ok_ff;
   logic [LW-1:0]  lbl_rd_ff;
   logic [MW-1:0]  moved_ff;
   logic [DistW-1:0] dist_acc_ff;
   logic [SqW-1:0]   sq_ff;
   logic [31:0]      prod_ff;
   logic [2:0][CoordW-1:0] vec_ff;
   logic [2:0][CoordW-1:0] pm_rd_ff;

   logic [3*CoordW-1:0] pmem [MAX_POINTS];
   logic [LW-1:0]       lmem [MAX_POINTS];

   logic accept_load, accept_query, load_fits, last_cell;
   logic [CW-1:0]          cnt_eff;
   logic [2:0][CoordW-1:0] ld_point;
   logic [CoordW-1:0]      range_sel;
   logic [CoordW:0]        dif;
   logic [CoordW:0]        dmag;

   kpc_cell_ctl_type ctl;

   logic                   link_valid [MAX_CLUSTERS+1];
   logic [2:0][CoordW-1:0] link_point [MAX_CLUSTERS+1];
   logic [DistW-1:0]       link_dist  [MAX_CLUSTERS+1];
   logic [LW-1:0]          link_label [MAX_CLUSTERS+1];
   logic [2:0][CoordW-1:0] center_arr [MAX_CLUSTERS];
   logic [CW-1:0]          count_arr  [MAX_CLUSTERS];
   logic [2:0][SUM_W-1:0]  sum_arr    [MAX_CLUSTERS];

   logic                 div_start, div_done;
   logic [SUM_W-1:0]     div_q;
   logic                 sqrt_start, sqrt_done;
   logic [DistW/2-1:0]   sqrt_root;

   // effective configuration
   always_comb begin
      if (num_clusters_ff == '0) begin
         k_eff = KW'(1);
      end else if (int'(num_clusters_ff) > MAX_CLUSTERS) begin
         k_eff = KW'(MAX_CLUSTERS);
      end else begin
         k_eff = KW'(num_clusters_ff);
      end
   end

   assign cap_eff   = (max_iter_ff == '0) ? 8'd1 : max_iter_ff;
   assign iter_nx   = iter_ff + 1'b1;
   assign lfsr_nx   = lfsr_step(lfsr_ff);
   assign last_cell = (KW'(cell_ff) == (k_eff - 1'b1));

   assign accept_load  = start && !busy && (req_data.op == OP_LOAD);
   assign accept_query = start && !busy && (req_data.op == OP_QUERY);
   assign ld_point     = {req_data.coord_z, req_data.coord_y, req_data.coord_x};
   assign cnt_eff      = batch_done_ff ? '0 : point_count_ff;
   assign load_fits    = cnt_eff < CW'(MAX_POINTS);

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         box_min_eff[a] = batch_done_ff ? {1'b0, {(CoordW-1){1'b1}}} : box_min_ff[a];
         box_max_eff[a] = batch_done_ff ? {1'b1, {(CoordW-1){1'b0}}} : box_max_ff[a];
      end
   end

   assign range_sel = box_max_ff[axis_ff] - box_min_ff[axis_ff];
   assign dif  = {vec_ff[axis_ff][CoordW-1], vec_ff[axis_ff]} -
                 {center_arr[cell_ff][axis_ff][CoordW-1], center_arr[cell_ff][axis_ff]};
   assign dmag = dif[CoordW] ? (~dif + 1'b1) : dif;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (accept_load && req_data.is_last) state_in = ST_SEED_STEP;
         ST_SEED_STEP:  state_in = ST_SEED_WR;
         ST_SEED_WR:    state_in = (axis_ff == 2'd2) ? ST_SEED_PUT : ST_SEED_STEP;
         ST_SEED_PUT:   state_in = last_cell ? ST_ITER_START : ST_SEED_STEP;
         ST_ITER_START: state_in = ST_ASSIGN;
         ST_ASSIGN: begin
            if ((feed_ff == point_count_ff) && (tail_ff == point_count_ff)) begin
               state_in = ST_UPD_CHECK;
            end
         end
         ST_UPD_CHECK:  state_in = (count_arr[cell_ff] == '0) ? ST_UPD_NEXT : ST_DIV_START;
         ST_DIV_START:  state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) state_in = (axis_ff == 2'd2) ? ST_DIST : ST_DIV_START;
         end
         ST_DIST:       state_in = ST_DIST_ACC;
         ST_DIST_ACC:   state_in = (axis_ff == 2'd2) ? ST_SQRT_START : ST_DIST;
         ST_SQRT_START: state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT:  if (sqrt_done) state_in = ST_UPD_PUT;
         ST_UPD_PUT:    state_in = ST_UPD_NEXT;
         ST_UPD_NEXT:   state_in = last_cell ? ST_ITER_END : ST_UPD_CHECK;
         ST_ITER_END: begin
            if ((moved_ff <= MW'(stop_thr_ff)) || (iter_nx >= cap_eff)) begin
               state_in = ST_REPORT;
            end else begin
               state_in = ST_ITER_START;
            end
         end
         ST_REPORT:     state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      busy       = (state_ff != ST_IDLE);
      rsp_valid  = q_pend_ff || (state_ff == ST_REPORT);
      ctl.clear  = (state_ff == ST_ITER_START);
      ctl.write  = (state_ff == ST_SEED_PUT) || (state_ff == ST_UPD_PUT);
      ctl.accum  = link_valid[MAX_CLUSTERS];
      div_start  = (state_ff == ST_DIV_START);
      sqrt_start = (state_ff == ST_SQRT_START);
      rsp_data.kind            = q_pend_ff ? KIND_LABEL : KIND_REPORT;
      rsp_data.cluster_label   = (q_pend_ff && q_ok_ff) ? 3'(lbl_rd_ff) : 3'd0;
      rsp_data.label_valid     = q_pend_ff && q_ok_ff;
      rsp_data.iterations_used = iter_ff;
      rsp_data.converged       = conv_ff;
      rsp_data.overflowed      = ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         num_clusters_ff <= 4'd3;
         stop_thr_ff     <= 16'd26;
         max_iter_ff     <= 8'd100;
         lfsr_ff         <= 32'd1;
         point_count_ff  <= '0;
         for (int a = 0; a < 3; a++) begin
            box_min_ff[a] <= {1'b0, {(CoordW-1){1'b1}}};
            box_max_ff[a] <= {1'b1, {(CoordW-1){1'b0}}};
         end
         batch_done_ff <= 1'b0;
         ovf_ff        <= 1'b0;
         conv_ff       <= 1'b0;
         iter_ff       <= '0;
         cell_ff       <= '0;
         axis_ff       <= '0;
         feed_ff       <= '0;
         tail_ff       <= '0;
         feed_v_ff     <= 1'b0;
         q_pend_ff     <= 1'b0;
         moved_ff      <= '0;
         dist_acc_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         q_pend_ff <= accept_query;
         feed_v_ff <= (state_ff == ST_ASSIGN) && (feed_ff < point_count_ff);

         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_NUM_CLUSTERS:   num_clusters_ff <= csr_wdata[3:0];
               CSR_STOP_THRESHOLD: stop_thr_ff     <= csr_wdata[15:0];
               CSR_RANDOM_SEED:    lfsr_ff         <= (csr_wdata == '0) ? 32'd1 : csr_wdata;
               CSR_MAX_ITERATIONS: max_iter_ff     <= csr_wdata[7:0];
               default: ;
            endcase
         end

         if (accept_load) begin
            batch_done_ff <= 1'b0;
            ovf_ff        <= (batch_done_ff ? 1'b0 : ovf_ff) | !load_fits;
            if (load_fits) begin
               point_count_ff <= cnt_eff + 1'b1;
               for (int a = 0; a < 3; a++) begin
                  box_min_ff[a] <= ($signed(ld_point[a]) < $signed(box_min_eff[a])) ?
                                   ld_point[a] : box_min_eff[a];
                  box_max_ff[a] <= ($signed(ld_point[a]) > $signed(box_max_eff[a])) ?
                                   ld_point[a] : box_max_eff[a];
               end
            end else begin
               point_count_ff <= cnt_eff;
               box_min_ff     <= box_min_eff;
               box_max_ff     <= box_max_eff;
            end
            if (req_data.is_last) begin
               iter_ff <= '0;
               cell_ff <= '0;
               axis_ff <= '0;
            end
         end

         case (state_ff)
            ST_SEED_STEP: lfsr_ff <= lfsr_nx;
            ST_SEED_WR:   axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 1'b1;
            ST_SEED_PUT:  cell_ff <= cell_ff + 1'b1;
            ST_ITER_START: begin
               feed_ff  <= '0;
               tail_ff  <= '0;
               cell_ff  <= '0;
               moved_ff <= '0;
            end
            ST_ASSIGN: begin
               if (feed_ff < point_count_ff) feed_ff <= feed_ff + 1'b1;
               if (link_valid[MAX_CLUSTERS]) tail_ff <= tail_ff + 1'b1;
            end
            ST_UPD_CHECK: axis_ff <= '0;
            ST_DIV_WAIT: begin
               if (div_done) begin
                  axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 1'b1;
                  dist_acc_ff <= '0;
               end
            end
            ST_DIST_ACC: begin
               dist_acc_ff <= dist_acc_ff + DistW'(sq_ff);
               axis_ff     <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 1'b1;
            end
            ST_SQRT_WAIT: if (sqrt_done) moved_ff <= moved_ff + MW'(sqrt_root);
            ST_UPD_NEXT:  cell_ff <= cell_ff + 1'b1;
            ST_ITER_END: begin
               iter_ff <= iter_nx;
               conv_ff <= (moved_ff <= MW'(stop_thr_ff));
            end
            ST_REPORT:    batch_done_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // datapath and stores
   always_ff @(posedge clock) begin
      if (accept_load && load_fits) begin
         pmem[cnt_eff[AW-1:0]] <= ld_point;
      end
      pm_rd_ff <= pmem[feed_ff[AW-1:0]];
      if (link_valid[MAX_CLUSTERS]) begin
         lmem[tail_ff[AW-1:0]] <= link_label[MAX_CLUSTERS];
      end
      lbl_rd_ff <= lmem[AW'(req_data.point_index)];
      q_ok_ff   <= CW'(req_data.point_index) < point_count_ff;
      if (state_ff == ST_SEED_STEP) begin
         prod_ff <= 32'(range_sel) * 32'(lfsr_nx[31:16]);
      end
      if (state_ff == ST_SEED_WR) begin
         vec_ff[axis_ff] <= box_min_ff[axis_ff] + prod_ff[31:16];
      end
      if ((state_ff == ST_DIV_WAIT) && div_done) begin
         vec_ff[axis_ff] <= div_q[CoordW-1:0];
      end
      if (state_ff == ST_DIST) begin
         sq_ff <= SqW'(dmag) * SqW'(dmag);
      end
   end

   // cell chain: cell 0 always takes its own distance
   assign link_valid[0] = feed_v_ff;
   assign link_point[0] = pm_rd_ff;
   assign link_dist[0]  = '1;
   assign link_label[0] = '0;

   for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
      kpc_cell #(
         .CELL_INDEX (i),
         .LABEL_W    (LW),
         .COUNT_W    (CW),
         .SUM_W      (SUM_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (KW'(i) < k_eff),
         .ctl       (ctl),
         .wr_sel    (cell_ff),
         .wr_center (vec_ff),
         .in_valid  (link_valid[i]),
         .in_point  (link_point[i]),
         .in_dist   (link_dist[i]),
         .in_label  (link_label[i]),
         .out_valid (link_valid[i+1]),
         .out_point (link_point[i+1]),
         .out_dist  (link_dist[i+1]),
         .out_label (link_label[i+1]),
         .acc_label (link_label[MAX_CLUSTERS]),
         .acc_point (link_point[MAX_CLUSTERS]),
         .center_q  (center_arr[i]),
         .count_q   (count_arr[i]),
         .sum_q     (sum_arr[i])
      );
   end

   kpc_divider #(
      .NUM_W (SUM_W),
      .DEN_W (CW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start_div (div_start),
      .numer     (sum_arr[cell_ff][axis_ff]),
      .denom     (count_arr[cell_ff]),
      .done      (div_done),
      .quotient  (div_q)
   );

   kpc_isqrt #(
      .VAL_W (DistW)
   ) u_isqrt (
      .clock      (clock),
      .reset      (reset),
      .start_sqrt (sqrt_start),
      .value      (dist_acc_ff),
      .done       (sqrt_done),
      .root       (sqrt_root)
   );

   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ASSIGN) |-> (tail_ff <= point_count_ff))
      else $error("assignment tail passed the point count");

   a_chain_in_assign: assert property (@(posedge clock) disable iff (reset)
      link_valid[MAX_CLUSTERS] |-> (state_ff == ST_ASSIGN))
      else $error("chain item outside assignment");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ctl.write |-> (KW'(cell_ff) < k_eff))
      else $error("center write to unused cell");

   a_report_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT) |=> ((state_ff == ST_IDLE) && batch_done_ff))
      else $error("report not followed by idle batch");

endmodule

// File: rtl/kpc_cell.sv
// One cluster cell: holds a center and member sums, compares each passing point.
module kpc_cell import kpc_pkg::*; #(
   parameter int CELL_INDEX = 0,
   parameter int LABEL_W    = 3,
   parameter int COUNT_W    = 11,
   parameter int SUM_W      = 27
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  kpc_cell_ctl_type              ctl,
   input  logic [LABEL_W-1:0]            wr_sel,
   input  logic [2:0][CoordW-1:0]        wr_center,
   input  logic                          in_valid,
   input  logic [2:0][CoordW-1:0]        in_point,
   input  logic [DistW-1:0]              in_dist,
   input  logic [LABEL_W-1:0]            in_label,
   output logic                          out_valid,
   output logic [2:0][CoordW-1:0]        out_point,
   output logic [DistW-1:0]              out_dist,
   output logic [LABEL_W-1:0]            out_label,
   input  logic [LABEL_W-1:0]            acc_label,
   input  logic [2:0][CoordW-1:0]        acc_point,
   output logic [2:0][CoordW-1:0]        center_q,
   output logic [COUNT_W-1:0]            count_q,
   output logic [2:0][SUM_W-1:0]         sum_q
);

   localparam logic [LABEL_W-1:0] MyLabel = LABEL_W'(CELL_INDEX);

   logic [2:0][CoordW-1:0] center_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [2:0][SUM_W-1:0]  sum_ff;

   logic                   v1_ff;
   logic [2:0][CoordW-1:0] p1_ff;
   logic [DistW-1:0]       d1_ff;
   logic [LABEL_W-1:0]     l1_ff;
   logic [2:0][SqW-1:0]    sq1_ff;

   logic                   v2_ff;
   logic [2:0][CoordW-1:0] p2_ff;
   logic [DistW-1:0]       d2_ff;
   logic [LABEL_W-1:0]     l2_ff;

   logic [2:0][CoordW:0]   diff;
   logic [2:0][CoordW:0]   mag;
   logic [2:0][SqW-1:0]    sq_in;
   logic [DistW-1:0]       dsum;
   logic                   take;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff[a]  = {in_point[a][CoordW-1], in_point[a]} - {center_ff[a][CoordW-1], center_ff[a]};
         mag[a]   = diff[a][CoordW] ? (~diff[a] + 1'b1) : diff[a];
         sq_in[a] = SqW'(mag[a]) * SqW'(mag[a]);
      end
   end

   assign dsum = DistW'(sq1_ff[0]) + DistW'(sq1_ff[1]) + DistW'(sq1_ff[2]);
   assign take = enable && (dsum < d1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff  <= in_point;
      d1_ff  <= in_dist;
      l1_ff  <= in_label;
      sq1_ff <= sq_in;
      p2_ff  <= p1_ff;
      d2_ff  <= take ? dsum : d1_ff;
      l2_ff  <= take ? MyLabel : l1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
      end else begin
         if (ctl.write && (wr_sel == MyLabel)) begin
            center_ff <= wr_center;
         end
         if (ctl.clear) begin
            count_ff <= '0;
            sum_ff   <= '0;
         end else if (ctl.accum && (acc_label == MyLabel)) begin
            count_ff <= count_ff + 1'b1;
            for (int a = 0; a < 3; a++) begin
               sum_ff[a] <= sum_ff[a] +
                            {{(SUM_W-CoordW){acc_point[a][CoordW-1]}}, acc_point[a]};
            end
         end
      end
   end

   assign out_valid = v2_ff;
   assign out_point = p2_ff;
   assign out_dist  = d2_ff;
   assign out_label = l2_ff;
   assign center_q  = center_ff;
   assign count_q   = count_ff;
   assign sum_q     = sum_ff;

endmodule

// File: rtl/kpc_divider.sv
// Bit-serial signed-by-unsigned divider, quotient truncated toward zero.
module kpc_divider import kpc_pkg::*; #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start_div,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CntW = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CntW-1:0]  cnt_ff;
   logic             neg_ff;
   logic [NUM_W-1:0] acc_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   rem_shift;
   logic             ge;

   assign rem_shift = {rem_ff, acc_ff[NUM_W-1]};
   assign ge        = rem_shift >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start_div) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntW'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_div) begin
         neg_ff <= numer[NUM_W-1];
         acc_ff <= numer[NUM_W-1] ? (~numer + 1'b1) : numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         rem_ff <= ge ? DEN_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DEN_W-1:0];
         acc_ff <= {acc_ff[NUM_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~acc_ff + 1'b1) : acc_ff;

endmodule

// File: rtl/kpc_isqrt.sv
// Iterative floor integer square root, two radicand bits per cycle.
module kpc_isqrt import kpc_pkg::*; #(
   parameter int VAL_W = 36
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start_sqrt,
   input  logic [VAL_W-1:0]   value,
   output logic               done,
   output logic [VAL_W/2-1:0] root
);

   logic             busy_ff;
   logic             done_ff;
   logic [VAL_W-1:0] v_ff;
   logic [VAL_W-1:0] r_ff;
   logic [VAL_W-1:0] bit_ff;
   logic [VAL_W-1:0] trial;
   logic             ge;

   assign trial = r_ff + bit_ff;
   assign ge    = v_ff >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start_sqrt) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff[0]) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_sqrt) begin
         v_ff   <= value;
         r_ff   <= '0;
         bit_ff <= VAL_W'(1) << (VAL_W - 2);
      end else if (busy_ff) begin
         if (ge) begin
            v_ff <= v_ff - trial;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = r_ff[VAL_W/2-1:0];

endmodule
